>>> hw/rtl/fcd_pkg.sv
// ----------------------------------------------------------------------------
// fcd_pkg: shared types and constants of the frame cache slot manager
// Field widths, op and status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package fcd_pkg;

  // default sizes
  localparam int unsigned SlotCountDef  = 16;
  localparam int unsigned LengthBitsDef = 24;
  localparam int unsigned FrameBitsDef  = 31;

  // fixed widths of the channel words
  localparam int unsigned OpW       = 2;
  localparam int unsigned FrameInW  = 31;
  localparam int unsigned LengthInW = 24;
  localparam int unsigned FormatW   = 8;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned SlotOutW  = 4;
  localparam int unsigned MibW      = 9;

  // bytes -> mebibytes is a shift by 20, result saturates
  localparam int unsigned MibShift = 20;
  localparam int unsigned MibMax   = 511;

  typedef enum logic [OpW-1:0] {
    OP_STORE  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2
  } fcd_op_e;

  typedef enum logic [StatusW-1:0] {
    STAT_STORED  = 3'd0,
    STAT_IGNORED = 3'd1,
    STAT_HIT     = 3'd2,
    STAT_MISS    = 3'd3,
    STAT_CLEARED = 3'd4
  } fcd_status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_CLEAR,
    FSM_SCAN,
    FSM_WRITE,
    FSM_ADD,
    FSM_RESP
  } fcd_state_e;

endpackage

>>> hw/rtl/fcd_in_if.sv
// ----------------------------------------------------------------------------
// fcd_in_if: request channel of the frame cache slot manager
// Valid/ready handshake carrying one request word.
// ----------------------------------------------------------------------------
interface fcd_in_if import fcd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OpW-1:0]       op;
  logic [FrameInW-1:0]  frame_number;
  logic [LengthInW-1:0] length_in;
  logic [FormatW-1:0]   format_in;

  modport source (output valid, output op, output frame_number, output length_in,
                  output format_in, input ready);
  modport sink   (input valid, input op, input frame_number, input length_in,
                  input format_in, output ready);
endinterface

>>> hw/rtl/fcd_out_if.sv
// ----------------------------------------------------------------------------
// fcd_out_if: response channel of the frame cache slot manager
// Valid/ready handshake carrying one response word.
// ----------------------------------------------------------------------------
interface fcd_out_if import fcd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [StatusW-1:0]   status;
  logic [SlotOutW-1:0]  slot;
  logic [LengthInW-1:0] length_out;
  logic [FormatW-1:0]   format_out;
  logic [MibW-1:0]      used_mebibytes;

  modport source (output valid, output status, output slot, output length_out,
                  output format_out, output used_mebibytes, input ready);
  modport sink   (input valid, input status, input slot, input length_out,
                  input format_out, input used_mebibytes, output ready);
endinterface

>>> hw/rtl/frame_cache_distance_replacement.sv
// ----------------------------------------------------------------------------
// frame_cache_distance_replacement: tag and size manager for frame cache slots
// Keeps frame number, byte length and format per slot and a running byte
// total; picks the slot to fill on store and finds the slot on lookup.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one request word (op, frame_number, length_in, format_in),
//   out_o returns exactly one response word per request, in order.
//   Ops: store, lookup, clear. A store with zero length changes nothing.
//   A store fills the lowest empty slot, or evicts the slot whose frame
//   number is farthest from the new one (ties go to the lowest slot).
//   The returned slot number addresses an external frame memory.
// Sequencing:
//   store and lookup walk the slot RAM one entry per cycle through a single
//   distance/compare unit; a store then writes its slot, subtracts any
//   evicted length and adds its own. Clear empties all slots first; an
//   ignored store or unused op responds directly. After the response word is
//   loaded the sequencer returns to idle, the only state taking a request.
// Reset: all slots empty and the byte total zero at once; the slot RAM is
//   never cleared, only entries marked valid are trusted.
// Stall: the response sits in an output register; a new request may be
//   taken while it waits, but the next response waits until it is drained.
// ----------------------------------------------------------------------------
module frame_cache_distance_replacement
  import fcd_pkg::*;
#(
  parameter int unsigned SLOT_COUNT  = SlotCountDef,
  parameter int unsigned LENGTH_BITS = LengthBitsDef,
  parameter int unsigned FRAME_BITS  = FrameBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fcd_in_if.sink    in_i,
  fcd_out_if.source out_o
);

  // stored length width: the request field is only 24 bits wide
  localparam int unsigned LenW   = (LENGTH_BITS < LengthInW) ? LENGTH_BITS : LengthInW;
  localparam int unsigned SlotW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CntW   = $clog2(SLOT_COUNT + 1);
  localparam int unsigned TotW   = LenW + $clog2(SLOT_COUNT + 1);
  localparam int unsigned EntryW = FRAME_BITS + LenW + FormatW;

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  fcd_state_e state_q, state_d;

  // latched request word
  logic [OpW-1:0]        op_q;
  logic [FRAME_BITS-1:0] frame_q;
  logic [LenW-1:0]       len_q;
  logic [FormatW-1:0]    fmt_q;

  // slot bookkeeping
  logic [SLOT_COUNT-1:0] valid_q;
  logic [TotW-1:0]       total_q;

  // scan sequencer
  logic [CntW-1:0]  cnt_q;
  logic             eval_vld_q;
  logic [SlotW-1:0] eval_idx_q;

  // scan results
  logic                  free_found_q;
  logic [SlotW-1:0]      free_idx_q;
  logic [FRAME_BITS-1:0] far_q;
  logic [SlotW-1:0]      best_idx_q;
  logic [LenW-1:0]       best_len_q;
  logic                  hit_q;
  logic [SlotW-1:0]      hit_idx_q;
  logic [LenW-1:0]       hit_len_q;
  logic [FormatW-1:0]    hit_fmt_q;

  // response register
  logic                 out_valid_q;
  logic [StatusW-1:0]   out_status_q;
  logic [SlotOutW-1:0]  out_slot_q;
  logic [LengthInW-1:0] out_len_q;
  logic [FormatW-1:0]   out_fmt_q;
  logic [MibW-1:0]      out_mib_q;

  // strobes from the sequencer
  logic in_ready;
  logic accept;
  logic rd_en;
  logic wr_en;
  logic load_out;

  // --------------------------------------------------------------------------
  // slot RAM: {frame, length, format}
  // --------------------------------------------------------------------------
  logic [SlotW-1:0]  wr_idx;
  logic [EntryW-1:0] rdata;

  assign wr_idx = free_found_q ? free_idx_q : best_idx_q;

  fcd_ram #(
    .WIDTH(EntryW),
    .DEPTH(SLOT_COUNT)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_idx),
    .wdata_i({frame_q, len_q, fmt_q}),
    .re_i   (rd_en),
    .raddr_i(cnt_q[SlotW-1:0]),
    .rdata_o(rdata)
  );

  logic [FRAME_BITS-1:0] ent_frame;
  logic [LenW-1:0]       ent_len;
  logic [FormatW-1:0]    ent_fmt;
  logic                  ent_valid;

  assign ent_frame = rdata[EntryW-1 -: FRAME_BITS];
  assign ent_len   = rdata[FormatW +: LenW];
  assign ent_fmt   = rdata[FormatW-1:0];
  assign ent_valid = valid_q[eval_idx_q];

  // --------------------------------------------------------------------------
  // shared distance / compare unit
  // --------------------------------------------------------------------------
  logic [FRAME_BITS:0]   diff;
  logic [FRAME_BITS-1:0] frame_dist;
  logic                  farther;
  logic                  match;

  assign diff       = {1'b0, ent_frame} - {1'b0, frame_q};
  assign frame_dist = diff[FRAME_BITS] ? (frame_q - ent_frame) : diff[FRAME_BITS-1:0];
  // slot 0 always seeds the victim so an all-zero distance picks it
  assign farther    = (frame_dist > far_q) || (eval_idx_q == '0);
  assign match      = ent_frame == frame_q;

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  logic scan_done;
  assign scan_done = cnt_q == CntW'(SLOT_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    in_ready = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      FSM_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          case (fcd_op_e'(in_i.op))
            OP_STORE:  state_d = (in_i.length_in[LenW-1:0] == '0) ? FSM_RESP : FSM_SCAN;
            OP_LOOKUP: state_d = FSM_SCAN;
            OP_CLEAR:  state_d = FSM_CLEAR;
            default:   state_d = FSM_RESP;
          endcase
        end
      end
      FSM_CLEAR: begin
        state_d = FSM_RESP;
      end
      FSM_SCAN: begin
        rd_en = !scan_done;
        if (scan_done) begin
          state_d = (op_q == OP_STORE) ? FSM_WRITE : FSM_RESP;
        end
      end
      FSM_WRITE: begin
        wr_en   = 1'b1;
        state_d = FSM_ADD;
      end
      FSM_ADD: begin
        state_d = FSM_RESP;
      end
      FSM_RESP: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  assign accept = in_ready && in_i.valid;

  // request word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_i.op;
      frame_q <= in_i.frame_number[FRAME_BITS-1:0];
      len_q   <= in_i.length_in[LenW-1:0];
      fmt_q   <= in_i.format_in;
    end
  end

  // control: counter, flags, valid bits, byte total
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      eval_vld_q   <= 1'b0;
      free_found_q <= 1'b0;
      hit_q        <= 1'b0;
      valid_q      <= '0;
      total_q      <= '0;
    end else begin
      eval_vld_q <= rd_en;
      if (accept) begin
        cnt_q        <= '0;
        free_found_q <= 1'b0;
        hit_q        <= 1'b0;
      end else if (rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (eval_vld_q) begin
        if (!free_found_q && !ent_valid) begin
          free_found_q <= 1'b1;
        end
        if (!hit_q && ent_valid && match) begin
          hit_q <= 1'b1;
        end
      end
      if (state_q == FSM_CLEAR) begin
        valid_q <= '0;
        total_q <= '0;
      end
      if (wr_en) begin
        valid_q[wr_idx] <= 1'b1;
        total_q         <= total_q - (free_found_q ? '0 : TotW'(best_len_q));
      end
      if (state_q == FSM_ADD) begin
        total_q <= total_q + TotW'(len_q);
      end
    end
  end

  // scan payload
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      eval_idx_q <= cnt_q[SlotW-1:0];
    end
    if (accept) begin
      far_q      <= '0;
      best_idx_q <= '0;
    end else if (eval_vld_q) begin
      if (!free_found_q && !ent_valid) begin
        free_idx_q <= eval_idx_q;
      end
      if (farther) begin
        far_q      <= frame_dist;
        best_idx_q <= eval_idx_q;
        best_len_q <= ent_len;
      end
      if (!hit_q && ent_valid && match) begin
        hit_idx_q <= eval_idx_q;
        hit_len_q <= ent_len;
        hit_fmt_q <= ent_fmt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // response word
  // --------------------------------------------------------------------------
  fcd_status_e          resp_status;
  logic [SlotOutW-1:0]  resp_slot;
  logic [LengthInW-1:0] resp_len;
  logic [FormatW-1:0]   resp_fmt;
  logic [TotW-1:0]      mib_full;
  logic [MibW-1:0]      resp_mib;

  always_comb begin
    resp_status = STAT_MISS;
    resp_slot   = '0;
    resp_len    = '0;
    resp_fmt    = '0;
    case (fcd_op_e'(op_q))
      OP_STORE: begin
        if (len_q == '0) begin
          resp_status = STAT_IGNORED;
        end else begin
          resp_status = STAT_STORED;
          resp_slot   = SlotOutW'(wr_idx);
        end
      end
      OP_LOOKUP: begin
        if (hit_q) begin
          resp_status = STAT_HIT;
          resp_slot   = SlotOutW'(hit_idx_q);
          resp_len    = LengthInW'(hit_len_q);
          resp_fmt    = hit_fmt_q;
        end
      end
      OP_CLEAR: resp_status = STAT_CLEARED;
      default:  resp_status = STAT_MISS;
    endcase
  end

  assign mib_full = total_q >> MibShift;
  assign resp_mib = (32'(mib_full) > MibMax) ? MibW'(MibMax) : MibW'(mib_full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= resp_status;
      out_slot_q   <= resp_slot;
      out_len_q    <= resp_len;
      out_fmt_q    <= resp_fmt;
      out_mib_q    <= resp_mib;
    end
  end

  assign in_i.ready           = in_ready;
  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.slot           = out_slot_q;
  assign out_o.length_out     = out_len_q;
  assign out_o.format_out     = out_fmt_q;
  assign out_o.used_mebibytes = out_mib_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_resp_from_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == FSM_RESP))
    else $error("response word raised outside the response step");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(SLOT_COUNT))
    else $error("scan counter ran past the slot count");

  a_empty_total : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q == '0) |-> (total_q == '0))
    else $error("byte total nonzero with all slots empty");

  a_write_marks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_WRITE) |=> (valid_q != '0) && (state_q == FSM_ADD))
    else $error("slot write left no valid slot");

endmodule

>>> hw/rtl/fcd_ram.sv
// ----------------------------------------------------------------------------
// fcd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
